// File: rtl/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg: shared types for the GCD / LCM unit
// Item structs, datapath operation codes and the control/status bundles
// passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package glu_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic [31:0] divisor;
        logic [63:0] multiple;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_STRIP,
        OP_REDUCE,
        OP_PICK,
        OP_SCALE,
        OP_DIV_INIT,
        OP_DIV,
        OP_MUL_INIT,
        OP_MUL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic both_even;
        logic k_zero;
        logic opnd_zero;
    } dp_status_t;

endpackage

// File: rtl/glu_datapath.sv
// ----------------------------------------------------------------------------
// glu_datapath: operand registers and shared adder/subtractor
// One W+1-bit add/subtract unit serves the binary GCD steps, the restoring
// divide of operand_a by the divisor and the shift-add multiply by operand_b.
// ----------------------------------------------------------------------------
module glu_datapath
    import glu_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic        aclk,
    input  in_item_t    in_item,
    input  dp_ctrl_t    ctrl,
    output dp_status_t  status,
    output logic [31:0] divisor,
    output logic [63:0] multiple
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dq_reg, dq_next;
    logic [W-1:0]     hi_reg, hi_next;
    logic [W-1:0]     lo_reg, lo_next;

    // shared unit
    logic [W:0]   op1, op2;
    logic         sub;
    logic [W+1:0] res;
    logic         ge;

    always_comb begin
        op1 = {1'b0, x_reg};
        op2 = {1'b0, y_reg};
        sub = 1'b1;
        case (ctrl.op)
            OP_DIV: begin
                op1 = {rem_reg, dq_reg[W-1]};
                op2 = {1'b0, x_reg};
                sub = 1'b1;
            end
            OP_MUL: begin
                op1 = {1'b0, hi_reg};
                op2 = {1'b0, dq_reg};
                sub = 1'b0;
            end
            default: begin
                op1 = {1'b0, x_reg};
                op2 = {1'b0, y_reg};
                sub = 1'b1;
            end
        endcase
        res = {1'b0, op1} + {1'b0, op2 ^ {(W+1){sub}}} + {{(W+1){1'b0}}, sub};
    end

    // carry out of a subtract means no borrow
    assign ge = res[W+1];

    always_comb begin
        a_next   = a_reg;
        b_next   = b_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        k_next   = k_reg;
        rem_next = rem_reg;
        dq_next  = dq_reg;
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        case (ctrl.op)
            OP_LOAD: begin
                a_next = in_item.operand_a[W-1:0];
                b_next = in_item.operand_b[W-1:0];
                x_next = in_item.operand_a[W-1:0];
                y_next = in_item.operand_b[W-1:0];
                k_next = '0;
            end
            OP_STRIP: begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + CNT_W'(1);
            end
            OP_REDUCE: begin
                if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (ge) begin
                    // difference of two odd values is even: halve it at once
                    x_next = {1'b0, res[W-1:1]};
                end else begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            OP_PICK: begin
                if (x_reg == '0) begin
                    x_next = y_reg;
                end
                hi_next = '0;
                lo_next = '0;
            end
            OP_SCALE: begin
                x_next = x_reg << 1;
                k_next = k_reg - CNT_W'(1);
            end
            OP_DIV_INIT: begin
                rem_next = '0;
                dq_next  = a_reg;
            end
            OP_DIV: begin
                rem_next = ge ? res[W-1:0] : op1[W-1:0];
                dq_next  = {dq_reg[W-2:0], ge};
            end
            OP_MUL_INIT: begin
                hi_next = '0;
                lo_next = b_reg;
            end
            OP_MUL: begin
                if (lo_reg[0]) begin
                    hi_next = res[W:1];
                    lo_next = {res[0], lo_reg[W-1:1]};
                end else begin
                    hi_next = hi_reg >> 1;
                    lo_next = {hi_reg[0], lo_reg[W-1:1]};
                end
            end
            default: begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    assign status.x_zero    = (x_reg == '0);
    assign status.y_zero    = (y_reg == '0);
    assign status.both_even = !x_reg[0] && !y_reg[0];
    assign status.k_zero    = (k_reg == '0);
    assign status.opnd_zero = (a_reg == '0) || (b_reg == '0);

    assign divisor  = 32'(x_reg);
    assign multiple = 64'({hi_reg, lo_reg});

endmodule

// File: rtl/glu_ctrl.sv
// ----------------------------------------------------------------------------
// glu_ctrl: sequencer for the GCD / LCM unit
// Steps the datapath through common-factor strip, binary GCD reduction,
// rescale, divide and multiply, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module glu_ctrl
    import glu_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic       out_free,
    input  dp_status_t status,
    output dp_ctrl_t   ctrl,
    output logic       idle,
    output logic       done
);

    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STRIP,
        ST_REDUCE,
        ST_PICK,
        ST_SCALE,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_MUL_INIT,
        ST_MULTIPLY,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_step;

    assign last_step = (cnt_reg == CNT_W'(OPERAND_WIDTH - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl.op    = OP_IDLE;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ctrl.op    = OP_LOAD;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (status.x_zero || status.y_zero) begin
                    state_next = ST_PICK;
                end else if (status.both_even) begin
                    ctrl.op = OP_STRIP;
                end else begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (status.x_zero || status.y_zero) begin
                    state_next = ST_PICK;
                end else begin
                    ctrl.op = OP_REDUCE;
                end
            end
            ST_PICK: begin
                ctrl.op    = OP_PICK;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (!status.k_zero) begin
                    ctrl.op = OP_SCALE;
                end else if (status.opnd_zero) begin
                    // lcm with a zero operand is zero: skip divide and multiply
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                ctrl.op    = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                ctrl.op  = OP_DIV;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step) begin
                    state_next = ST_MUL_INIT;
                end
            end
            ST_MUL_INIT: begin
                ctrl.op    = OP_MUL_INIT;
                cnt_next   = '0;
                state_next = ST_MULTIPLY;
            end
            ST_MULTIPLY: begin
                ctrl.op  = OP_MUL;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);

    // no new item may be taken straight after one is accepted
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !idle)
        else $error("glu_ctrl: idle right after accepting an item");

    // the divisor must be nonzero throughout the divide
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> !status.x_zero)
        else $error("glu_ctrl: divide by zero divisor");

    // rescale only applies to a nonzero reduced value
    a_scale_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE && !status.k_zero) |-> !status.x_zero)
        else $error("glu_ctrl: rescaling a zero divisor");

    // divide and multiply only run on nonzero operands
    a_no_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_INIT) |-> !status.opnd_zero)
        else $error("glu_ctrl: divide started with a zero operand");

endmodule

// File: rtl/gcd_lcm_unit.sv
// Each item runs through the binary GCD loop, then W restoring-divide steps and W
//   shift-add steps (W = OPERAND_WIDTH), all through one shared W+1-bit adder/subtractor;
//   divide and multiply are skipped when an operand is zero.
// Throughput: one item at a time; s_ready is high only while the sequencer idles.
// The result sits in an output register, so the next item is taken while it waits.
// Reset (aresetn, synchronous, active low) clears the sequencer and m_valid.
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// Binary GCD, then lcm = (operand_a / divisor) * operand_b, per input item.
// ----------------------------------------------------------------------------
module gcd_lcm_unit
    import glu_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    dp_ctrl_t    ctrl;
    dp_status_t  status;
    logic        idle;
    logic        done;
    logic        start;
    logic        out_free;
    logic [31:0] divisor;
    logic [63:0] multiple;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    assign s_ready  = idle;
    assign start    = s_valid && idle;
    assign out_free = !m_valid_reg || m_ready;

    glu_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl),
        .idle     (idle),
        .done     (done)
    );

    glu_datapath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .in_item  (s_item),
        .ctrl     (ctrl),
        .status   (status),
        .divisor  (divisor),
        .multiple (multiple)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (done) begin
            m_valid_next         = 1'b1;
            m_item_next.divisor  = divisor;
            m_item_next.multiple = multiple;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
